// ===== src/wpmh_pkg.sv =====
package wpmh_pkg;

	localparam int WORD_W = 64;

	// Commands to the chain word unit.
	localparam logic [2:0] OP_HOLD = 3'd0;
	localparam logic [2:0] OP_INIT = 3'd1;
	localparam logic [2:0] OP_STEP = 3'd2;
	localparam logic [2:0] OP_SUB  = 3'd3;
	localparam logic [2:0] OP_ROT  = 3'd4;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SEED   = 2'd0;
	localparam logic [1:0] CFG_LENGTH = 2'd1;
	localparam logic [1:0] CFG_DIGEST = 2'd2;
	localparam logic [1:0] CFG_SWAP   = 2'd3;

	localparam logic [WORD_W-1:0] ACC_LEFT  = 64'hefcdab8967452301;
	localparam logic [WORD_W-1:0] ACC_RIGHT = 64'h1032547698badcfe;

	localparam logic [WORD_W-1:0] MIX_CONST [8] = '{
		64'hFFFFFFFFFFFFFFC5,
		64'd13166748625691186689,
		64'd1573836600196043749,
		64'd1478582680485693857,
		64'd1584163446043636637,
		64'd1358537349836140151,
		64'd2849285319520710901,
		64'd2366157163652459183
	};

	localparam logic [5:0] START_PRIME [16] = '{
		6'd1, 6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17,
		6'd19, 6'd23, 6'd29, 6'd31, 6'd37, 6'd41, 6'd43, 6'd47
	};

	typedef struct packed {
		logic [2:0] op;
		logic       left;
		logic [2:0] idx;
	} chain_cmd_t;

	function automatic logic [WORD_W-1:0] swap64(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] y;
		for (int b = 0; b < 8; b++) begin
			y[8*b +: 8] = x[8*(7-b) +: 8];
		end
		return y;
	endfunction

	// Right rotation by the amount that belongs to each step of a round.
	function automatic logic [WORD_W-1:0] rotr_mix(input logic [WORD_W-1:0] x,
		input logic [2:0] idx);
		logic [WORD_W-1:0] y;
		case (idx)
			3'd0: y = {x[16:0], x[63:17]};
			3'd1: y = {x[18:0], x[63:19]};
			3'd2: y = {x[22:0], x[63:23]};
			3'd3: y = {x[28:0], x[63:29]};
			3'd4: y = {x[30:0], x[63:31]};
			3'd5: y = {x[36:0], x[63:37]};
			3'd6: y = {x[40:0], x[63:41]};
			default: y = {x[52:0], x[63:53]};
		endcase
		return y;
	endfunction

	function automatic logic [WORD_W-1:0] byte_mask(input logic [3:0] nb);
		logic [WORD_W-1:0] m;
		for (int b = 0; b < 8; b++) begin
			m[8*b +: 8] = (4'(b) < nb) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

// ===== src/wpmh_in_if.sv =====
interface wpmh_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] message_word;
	logic [3:0]  valid_bytes;
	logic        last_word;

	modport source(output valid, output message_word, output valid_bytes,
		output last_word, input ready);
	modport sink(input valid, input message_word, input valid_bytes,
		input last_word, output ready);
endinterface

// ===== src/wpmh_out_if.sv =====
interface wpmh_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic        digest_end;

	modport source(output valid, output digest_word, output digest_end, input ready);
	modport sink(input valid, input digest_word, input digest_end, output ready);
endinterface

// ===== src/wpmh_cfg_if.sv =====
interface wpmh_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [63:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== src/wpmh_chain.sv =====
module wpmh_chain (
	input  logic                        clk,
	input  wpmh_pkg::chain_cmd_t        cmd,
	input  logic [wpmh_pkg::WORD_W-1:0] base,
	input  logic [wpmh_pkg::WORD_W-1:0] blk_word,
	output logic [wpmh_pkg::WORD_W-1:0] head
);

	// Both halves rotate by one place after every step, so the word that a step
	// works on always sits at place 0 and the next one at place 1.
	logic [wpmh_pkg::WORD_W-1:0] lo_q [8];
	logic [wpmh_pkg::WORD_W-1:0] hi_q [8];
	logic [wpmh_pkg::WORD_W-1:0] acc_q;

	logic [wpmh_pkg::WORD_W-1:0] lo_pre [8];
	logic [wpmh_pkg::WORD_W-1:0] hi_pre [8];
	logic [wpmh_pkg::WORD_W-1:0] lo_nx [8];
	logic [wpmh_pkg::WORD_W-1:0] hi_nx [8];
	logic [wpmh_pkg::WORD_W-1:0] acc_in;
	logic [wpmh_pkg::WORD_W-1:0] acc_nx;
	logic [wpmh_pkg::WORD_W-1:0] acc_d;
	logic [wpmh_pkg::WORD_W-1:0] src;
	logic [wpmh_pkg::WORD_W-1:0] v;
	logic [wpmh_pkg::WORD_W-1:0] tgt;
	logic [wpmh_pkg::WORD_W-1:0] tgt_nx;
	logic                        tgt_lo;
	logic                        rot_lo;
	logic                        rot_hi;

	always_comb begin
		if (cmd.idx == 3'd0) begin
			acc_in = cmd.left ? wpmh_pkg::ACC_LEFT : wpmh_pkg::ACC_RIGHT;
		end else begin
			acc_in = acc_q;
		end
		src    = cmd.left ? lo_q[0] : hi_q[0];
		v      = wpmh_pkg::rotr_mix((src ^ blk_word) - wpmh_pkg::MIX_CONST[cmd.idx], cmd.idx);
		acc_nx = acc_in + v;
		// On the last step of a left round the carry lands in the high half.
		tgt_lo = cmd.left && (cmd.idx != 3'd7);
		tgt    = tgt_lo ? lo_q[1] : hi_q[1];
		tgt_nx = tgt - acc_nx;

		lo_pre = lo_q;
		hi_pre = hi_q;
		rot_lo = 1'b0;
		rot_hi = 1'b0;
		acc_d  = acc_q;
		unique case (cmd.op)
			wpmh_pkg::OP_INIT: begin
				for (int i = 0; i < 8; i++) begin
					lo_pre[i] = base + 64'(wpmh_pkg::START_PRIME[i]);
					hi_pre[i] = base + 64'(wpmh_pkg::START_PRIME[i+8]);
				end
			end
			wpmh_pkg::OP_STEP: begin
				if (cmd.left) begin
					lo_pre[0] = v;
					hi_pre[0] = hi_q[0] ^ v;
				end else begin
					hi_pre[0] = v;
					lo_pre[0] = lo_q[0] ^ v;
				end
				if (tgt_lo) begin
					lo_pre[1] = tgt_nx;
				end else begin
					hi_pre[1] = tgt_nx;
				end
				acc_d  = acc_nx;
				rot_lo = 1'b1;
				rot_hi = 1'b1;
			end
			wpmh_pkg::OP_SUB: begin
				lo_pre[0] = lo_q[0] - hi_q[0];
				rot_lo    = 1'b1;
				rot_hi    = 1'b1;
			end
			wpmh_pkg::OP_ROT: begin
				rot_lo = 1'b1;
			end
			default: begin
			end
		endcase

		for (int i = 0; i < 8; i++) begin
			lo_nx[i] = rot_lo ? lo_pre[3'(i + 1)] : lo_pre[i];
			hi_nx[i] = rot_hi ? hi_pre[3'(i + 1)] : hi_pre[i];
		end
	end

	always_ff @(posedge clk) begin
		lo_q  <= lo_nx;
		hi_q  <= hi_nx;
		acc_q <= acc_d;
	end

	assign head = lo_q[0];

endmodule

// ===== src/wide_pipe_message_hash_top.sv =====
// Wide-pipe message hash. Message words are taken one beat at a time; a word
// that does not finish a block of eight is stored and ready stays high, while
// a word that finishes a block holds ready low while the four mixing rounds
// run, since a single 64-bit mixing unit does one step per cycle. After the
// last word come the rounds of the tail block (after those of a full block if
// the last word also completes one), a fold of the high half into the low
// half, extra rounds, one per digest word, when digest_words is above 1, and
// then one output beat per digest word, lowest chain word first. Ready stays
// low from the last word until the final digest beat has been taken.
module wide_pipe_message_hash_top (
	input  logic              clk,
	input  logic              arst_n,
	wpmh_cfg_if.sink          cfg,
	wpmh_in_if.sink           msg,
	wpmh_out_if.source        digest
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MIX  = 2'd1;
	localparam logic [1:0] ST_SUB  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	localparam logic [1:0] PH_FULL = 2'd0;
	localparam logic [1:0] PH_TAIL = 2'd1;
	localparam logic [1:0] PH_XTRA = 2'd2;

	logic [wpmh_pkg::WORD_W-1:0] seed_q;
	logic [31:0]                 len_q;
	logic [3:0]                  dw_q;
	logic                        swap_q;
	logic [wpmh_pkg::WORD_W-1:0] base_q;

	logic [wpmh_pkg::WORD_W-1:0] buf_q [8];
	logic [2:0]                  pos_q;
	logic                        started_q;
	logic [3:0]                  tail_cnt_q;
	logic [7:0]                  pad_q;
	logic                        tail_pend_q;
	logic [1:0]                  state_q;
	logic [1:0]                  ph_q;
	logic [2:0]                  n_q;
	logic [2:0]                  rnd_q;

	logic                        in_acc;
	logic                        out_acc;
	logic [3:0]                  vb_eff;
	logic [6:0]                  rem;
	logic                        full_last;
	logic [7:0]                  pad_new;
	logic [wpmh_pkg::WORD_W-1:0] mask;
	logic [wpmh_pkg::WORD_W-1:0] merged;
	logic [2:0]                  dw_m1;
	logic                        last_step;
	logic [wpmh_pkg::WORD_W-1:0] blk_word;
	logic [wpmh_pkg::WORD_W-1:0] head;
	wpmh_pkg::chain_cmd_t        cmd;

	assign cfg.ready = 1'b1;
	assign msg.ready = (state_q == ST_IDLE);
	assign in_acc    = msg.valid && msg.ready;
	assign out_acc   = digest.valid && digest.ready;

	always_comb begin
		if (msg.last_word && (msg.valid_bytes <= 4'd8)) begin
			vb_eff = msg.valid_bytes;
		end else begin
			vb_eff = 4'd8;
		end
		rem       = {1'b0, pos_q, 3'b000} + 7'(vb_eff);
		full_last = msg.last_word && (pos_q == 3'd7) && (vb_eff == 4'd8);
		pad_new   = 8'h80 + {1'b0, rem};
		mask      = wpmh_pkg::byte_mask(vb_eff);
		merged    = (msg.message_word & mask) | ({8{pad_new}} & ~mask);

		if (dw_q == 4'd0) begin
			dw_m1 = 3'd0;
		end else if (dw_q > 4'd8) begin
			dw_m1 = 3'd7;
		end else begin
			dw_m1 = 3'(dw_q - 4'd1);
		end

		last_step = (n_q == 3'd7) && ((ph_q == PH_XTRA) ? (rnd_q == dw_m1) : (rnd_q == 3'd3));

		// A full block is taken with the byte order setting; the tail block, also
		// used by the extra rounds, is taken as is, padded past the received words.
		if (ph_q == PH_FULL) begin
			blk_word = swap_q ? wpmh_pkg::swap64(buf_q[n_q]) : buf_q[n_q];
		end else if ({1'b0, n_q} < tail_cnt_q) begin
			blk_word = buf_q[n_q];
		end else begin
			blk_word = {8{pad_q}};
		end

		cmd.op   = wpmh_pkg::OP_HOLD;
		cmd.left = 1'b0;
		cmd.idx  = n_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && !started_q) begin
					cmd.op = wpmh_pkg::OP_INIT;
				end
			end
			ST_MIX: begin
				cmd.op   = wpmh_pkg::OP_STEP;
				cmd.left = (ph_q == PH_XTRA) || rnd_q[0];
			end
			ST_SUB: begin
				cmd.op = wpmh_pkg::OP_SUB;
			end
			ST_EMIT: begin
				if (out_acc) begin
					cmd.op = wpmh_pkg::OP_ROT;
				end
			end
			default: begin
			end
		endcase
	end

	assign digest.valid       = (state_q == ST_EMIT);
	assign digest.digest_word = swap_q ? wpmh_pkg::swap64(head) : head;
	assign digest.digest_end  = (n_q == dw_m1);

	wpmh_chain u_chain (
		.clk      (clk),
		.cmd      (cmd),
		.base     (base_q),
		.blk_word (blk_word),
		.head     (head)
	);

	// The sum of seed and length is kept ready, so the start of a message needs
	// only the small prime added.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			len_q  <= '0;
			dw_q   <= 4'd1;
			swap_q <= 1'b0;
			base_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				wpmh_pkg::CFG_SEED: begin
					seed_q <= cfg.data;
					base_q <= cfg.data + 64'(len_q);
				end
				wpmh_pkg::CFG_LENGTH: begin
					len_q  <= cfg.data[31:0];
					base_q <= seed_q + 64'(cfg.data[31:0]);
				end
				wpmh_pkg::CFG_DIGEST: begin
					dw_q <= cfg.data[3:0];
				end
				wpmh_pkg::CFG_SWAP: begin
					swap_q <= cfg.data[0];
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			buf_q[pos_q] <= (msg.last_word && !full_last) ? merged : msg.message_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ph_q        <= PH_FULL;
			pos_q       <= '0;
			started_q   <= 1'b0;
			tail_cnt_q  <= '0;
			pad_q       <= '0;
			tail_pend_q <= 1'b0;
			n_q         <= '0;
			rnd_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						started_q <= 1'b1;
						n_q       <= '0;
						rnd_q     <= '0;
						if (!msg.last_word) begin
							pos_q <= pos_q + 3'd1;
							if (pos_q == 3'd7) begin
								state_q     <= ST_MIX;
								ph_q        <= PH_FULL;
								tail_pend_q <= 1'b0;
							end
						end else begin
							pos_q   <= '0;
							state_q <= ST_MIX;
							if (full_last) begin
								ph_q        <= PH_FULL;
								tail_pend_q <= 1'b1;
								tail_cnt_q  <= '0;
								pad_q       <= 8'h80;
							end else begin
								ph_q        <= PH_TAIL;
								tail_pend_q <= 1'b0;
								tail_cnt_q  <= {1'b0, pos_q} + 4'd1;
								pad_q       <= pad_new;
							end
						end
					end
				end
				ST_MIX: begin
					n_q <= n_q + 3'd1;
					if (last_step) begin
						rnd_q <= '0;
						case (ph_q)
							PH_FULL: begin
								if (tail_pend_q) begin
									ph_q        <= PH_TAIL;
									tail_pend_q <= 1'b0;
								end else begin
									state_q <= ST_IDLE;
								end
							end
							PH_TAIL: begin
								state_q <= ST_SUB;
							end
							default: begin
								state_q <= ST_EMIT;
							end
						endcase
					end else if (n_q == 3'd7) begin
						rnd_q <= rnd_q + 3'd1;
					end
				end
				ST_SUB: begin
					n_q <= n_q + 3'd1;
					if (n_q == 3'd7) begin
						if (dw_m1 != 3'd0) begin
							state_q <= ST_MIX;
							ph_q    <= PH_XTRA;
							rnd_q   <= '0;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						if (n_q == dw_m1) begin
							state_q   <= ST_IDLE;
							started_q <= 1'b0;
							n_q       <= '0;
						end else begin
							n_q <= n_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
